>>> rtl/tsaq_pkg.sv
// Shared widths, register indexes, command codes and reset values for the tilt slouch qualifier.
package tsaq_pkg;

	localparam int unsigned PITCH_W  = 15;
	localparam int unsigned DROP_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned MS_W     = 16;
	localparam int unsigned THRESH_W = 13;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned VIB_W    = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [MODE_W-1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_CLEAR     = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	typedef enum logic [VIB_W-1:0] {
		VIB_ALWAYS  = 2'd0,
		VIB_NO_LINK = 2'd1,
		VIB_NEVER   = 2'd2,
		VIB_OFF     = 2'd3
	} vib_t;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIB_MODE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_AUTOTARE  = 3'd5;

	localparam logic [THRESH_W-1:0] THRESHOLD_RST = 13'd960;
	localparam logic [MS_W-1:0]     DEBOUNCE_RST  = 16'd500;
	localparam logic [MS_W-1:0]     GRACE_RST     = 16'd5000;
	localparam logic [MS_W-1:0]     REPEAT_RST    = 16'd10000;
	localparam logic [MS_W-1:0]     AUTOTARE_RST  = 16'd2000;

endpackage

>>> rtl/tsaq_if.sv
// Sample and result channel interfaces for the tilt slouch qualifier.
interface tsaq_sample_if;
	import tsaq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [MODE_W-1:0]          mode;
	logic signed [PITCH_W-1:0]  pitch;
	logic                       link_connected;
	logic [TIME_W-1:0]          now_ms;

	modport source (output valid, mode, pitch, link_connected, now_ms, input ready);
	modport sink (input valid, mode, pitch, link_connected, now_ms, output ready);
endinterface

interface tsaq_result_if;
	import tsaq_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       calibrated;
	logic signed [DROP_W-1:0]   pitch_drop;
	logic                       instant_slouch;
	logic                       slouch_state;
	logic                       alert_pulse;
	logic                       calibrate_pulse;
	logic                       stop_request;

	modport source (output valid, calibrated, pitch_drop, instant_slouch, slouch_state,
		alert_pulse, calibrate_pulse, stop_request, input ready);
	modport sink (input valid, calibrated, pitch_drop, instant_slouch, slouch_state,
		alert_pulse, calibrate_pulse, stop_request, output ready);
endinterface

>>> rtl/tilt_slouch_alert_qualifier.sv
// Top level of the tilt slouch qualifier: input register, decision logic, result register.
//
// sample_ch carries one command per beat: a tilt sample, a calibrate command,
// a clear command or a no-op, each with pitch, link state and a millisecond timestamp.
// result_ch returns exactly one result beat per command, in order.
// The configuration port writes one register per cycle with cfg_wr_en high;
// write only while no command is in flight.
// A command accepted into the input register is evaluated from it against the
// held baseline, debounce, sustain and alert timers, and its result is loaded
// into the result register and offered on result_ch once that register is
// free or its beat is being taken.
// Throughput: one command per cycle while result_ch does not stall; the state
// update of one command is combinational compares and 32-bit wrapping
// subtractions, registered as the command advances, so the next command sees it at once.
// When result_ch stalls, the result register holds its beat and the input
// register still takes one more command; sample_ch.ready drops only when both
// are full.
// Reset clears calibration, auto-tare, debounced state and all timer valid
// bits, and loads the register defaults; both channels come up empty.
module tilt_slouch_alert_qualifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tsaq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tsaq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	tsaq_sample_if.sink                        sample_ch,
	tsaq_result_if.source                      result_ch
);
	import tsaq_pkg::*;

	// configuration
	logic [THRESH_W-1:0] thresh_q;
	logic [MS_W-1:0]     debounce_ms_q;
	logic [MS_W-1:0]     grace_ms_q;
	logic [MS_W-1:0]     repeat_ms_q;
	logic [VIB_W-1:0]    vib_mode_q;
	logic [MS_W-1:0]     autotare_ms_q;

	// input stage
	logic                      valid_s1;
	logic [MODE_W-1:0]         mode_s1;
	logic signed [PITCH_W-1:0] pitch_s1;
	logic                      link_s1;
	logic [TIME_W-1:0]         now_s1;

	// block state
	logic                      is_cal_q;
	logic signed [PITCH_W-1:0] baseline_q;
	logic                      tare_done_q;
	logic                      deb_slouch_q;
	logic [TIME_W-1:0]         deb_start_q;
	logic                      deb_run_q;
	logic [TIME_W-1:0]         sus_start_q;
	logic                      sus_run_q;
	logic [TIME_W-1:0]         last_alert_q;
	logic                      alert_given_q;

	// result stage
	logic                      out_valid_q;
	logic                      out_cal_q;
	logic signed [DROP_W-1:0]  out_drop_q;
	logic                      out_inst_q;
	logic                      out_state_q;
	logic                      out_alert_q;
	logic                      out_calp_q;
	logic                      out_stop_q;

	logic advance;
	logic accept;

	// next-state and result logic
	logic                      tare;
	logic                      cal_eff;
	logic signed [PITCH_W-1:0] base_eff;
	logic                      deb_cur;
	logic                      sus_run_cur;
	logic                      given_cur;
	logic signed [DROP_W-1:0]  drop;
	logic                      inst;
	logic [TIME_W-1:0]         deb_elapsed;
	logic [TIME_W-1:0]         sus_elapsed;
	logic [TIME_W-1:0]         rep_elapsed;
	logic                      allowed;

	logic                      n_is_cal;
	logic signed [PITCH_W-1:0] n_baseline;
	logic                      n_tare_done;
	logic                      n_deb_slouch;
	logic [TIME_W-1:0]         n_deb_start;
	logic                      n_deb_run;
	logic [TIME_W-1:0]         n_sus_start;
	logic                      n_sus_run;
	logic [TIME_W-1:0]         n_last_alert;
	logic                      n_alert_given;

	logic                      r_cal;
	logic signed [DROP_W-1:0]  r_drop;
	logic                      r_inst;
	logic                      r_state;
	logic                      r_alert;
	logic                      r_calp;
	logic                      r_stop;

	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign accept          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q      <= THRESHOLD_RST;
			debounce_ms_q <= DEBOUNCE_RST;
			grace_ms_q    <= GRACE_RST;
			repeat_ms_q   <= REPEAT_RST;
			vib_mode_q    <= VIB_ALWAYS;
			autotare_ms_q <= AUTOTARE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_THRESHOLD: thresh_q      <= cfg_wdata[THRESH_W-1:0];
				REG_DEBOUNCE:  debounce_ms_q <= cfg_wdata[MS_W-1:0];
				REG_GRACE:     grace_ms_q    <= cfg_wdata[MS_W-1:0];
				REG_REPEAT:    repeat_ms_q   <= cfg_wdata[MS_W-1:0];
				REG_VIB_MODE:  vib_mode_q    <= cfg_wdata[VIB_W-1:0];
				REG_AUTOTARE:  autotare_ms_q <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= sample_ch.mode;
			pitch_s1 <= sample_ch.pitch;
			link_s1  <= sample_ch.link_connected;
			now_s1   <= sample_ch.now_ms;
		end
	end

	always_comb begin
		tare        = !tare_done_q && (now_s1 >= {{(TIME_W-MS_W){1'b0}}, autotare_ms_q});
		cal_eff     = is_cal_q || tare;
		base_eff    = tare ? pitch_s1 : baseline_q;
		deb_cur     = tare ? 1'b0 : deb_slouch_q;
		sus_run_cur = tare ? 1'b0 : sus_run_q;
		given_cur   = tare ? 1'b0 : alert_given_q;

		drop = cal_eff ? ($signed({base_eff[PITCH_W-1], base_eff})
			- $signed({pitch_s1[PITCH_W-1], pitch_s1})) : '0;
		inst = cal_eff && (drop > $signed({{(DROP_W-THRESH_W){1'b0}}, thresh_q}));

		deb_elapsed = now_s1 - deb_start_q;
		sus_elapsed = now_s1 - sus_start_q;
		rep_elapsed = now_s1 - last_alert_q;
		allowed = (vib_mode_q == VIB_ALWAYS) || ((vib_mode_q == VIB_NO_LINK) && !link_s1);

		n_is_cal      = is_cal_q;
		n_baseline    = baseline_q;
		n_tare_done   = tare_done_q;
		n_deb_slouch  = deb_slouch_q;
		n_deb_start   = deb_start_q;
		n_deb_run     = deb_run_q;
		n_sus_start   = sus_start_q;
		n_sus_run     = sus_run_q;
		n_last_alert  = last_alert_q;
		n_alert_given = alert_given_q;

		r_cal   = is_cal_q;
		r_drop  = '0;
		r_inst  = 1'b0;
		r_state = 1'b0;
		r_alert = 1'b0;
		r_calp  = 1'b0;
		r_stop  = 1'b0;

		case (mode_s1)
			CMD_CALIBRATE: begin
				n_is_cal      = 1'b1;
				n_baseline    = pitch_s1;
				n_deb_slouch  = 1'b0;
				n_sus_run     = 1'b0;
				n_alert_given = 1'b0;
				r_cal         = 1'b1;
				r_calp        = 1'b1;
			end
			CMD_CLEAR: begin
				n_is_cal      = 1'b0;
				n_baseline    = '0;
				n_deb_slouch  = 1'b0;
				n_sus_run     = 1'b0;
				n_alert_given = 1'b0;
				r_cal         = 1'b0;
			end
			CMD_SAMPLE: begin
				n_tare_done   = tare_done_q || tare;
				n_is_cal      = cal_eff;
				n_baseline    = base_eff;
				n_deb_slouch  = deb_cur;
				n_sus_run     = sus_run_cur;
				n_alert_given = given_cur;

				if (inst != deb_cur) begin
					if (!deb_run_q) begin
						n_deb_start = now_s1;
						n_deb_run   = 1'b1;
					end else if (deb_elapsed >= {{(TIME_W-MS_W){1'b0}}, debounce_ms_q}) begin
						n_deb_slouch = inst;
						n_deb_run    = 1'b0;
					end
				end else begin
					n_deb_run = 1'b0;
				end

				if (cal_eff && n_deb_slouch && allowed) begin
					if (!sus_run_cur) begin
						n_sus_start = now_s1;
						n_sus_run   = 1'b1;
					end else if (sus_elapsed >= {{(TIME_W-MS_W){1'b0}}, grace_ms_q}) begin
						if (!given_cur
							|| (rep_elapsed >= {{(TIME_W-MS_W){1'b0}}, repeat_ms_q})) begin
							n_last_alert  = now_s1;
							n_alert_given = 1'b1;
							r_alert       = 1'b1;
						end
					end
				end else begin
					n_sus_run     = 1'b0;
					n_alert_given = 1'b0;
					r_stop        = !n_deb_slouch;
				end

				r_cal   = cal_eff;
				r_drop  = drop;
				r_inst  = inst;
				r_state = n_deb_slouch;
				r_calp  = tare;
			end
			default: begin
				r_cal   = is_cal_q;
				r_state = deb_slouch_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_cal_q      <= 1'b0;
			baseline_q    <= '0;
			tare_done_q   <= 1'b0;
			deb_slouch_q  <= 1'b0;
			deb_start_q   <= '0;
			deb_run_q     <= 1'b0;
			sus_start_q   <= '0;
			sus_run_q     <= 1'b0;
			last_alert_q  <= '0;
			alert_given_q <= 1'b0;
		end else if (advance) begin
			is_cal_q      <= n_is_cal;
			baseline_q    <= n_baseline;
			tare_done_q   <= n_tare_done;
			deb_slouch_q  <= n_deb_slouch;
			deb_start_q   <= n_deb_start;
			deb_run_q     <= n_deb_run;
			sus_start_q   <= n_sus_start;
			sus_run_q     <= n_sus_run;
			last_alert_q  <= n_last_alert;
			alert_given_q <= n_alert_given;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_cal_q   <= r_cal;
			out_drop_q  <= r_drop;
			out_inst_q  <= r_inst;
			out_state_q <= r_state;
			out_alert_q <= r_alert;
			out_calp_q  <= r_calp;
			out_stop_q  <= r_stop;
		end
	end

	assign result_ch.valid           = out_valid_q;
	assign result_ch.calibrated      = out_cal_q;
	assign result_ch.pitch_drop      = out_drop_q;
	assign result_ch.instant_slouch  = out_inst_q;
	assign result_ch.slouch_state    = out_state_q;
	assign result_ch.alert_pulse     = out_alert_q;
	assign result_ch.calibrate_pulse = out_calp_q;
	assign result_ch.stop_request    = out_stop_q;

endmodule
